FILE: src/tff_pkg.sv
// ----------------------------------------------------------------------------
// Tool frame package
// Shared types and constants of the tool frame pipeline.
// ----------------------------------------------------------------------------
package tff_pkg;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned QUOT_BITS  = 15;

   localparam logic [15:0] DIR_X_RESET = 16'h0000;
   localparam logic [15:0] DIR_Y_RESET = 16'h4000;
   localparam logic [15:0] DIR_Z_RESET = 16'h0000;

   typedef enum logic [1:0] {
      CSR_DIR_X = 2'd0,
      CSR_DIR_Y = 2'd1,
      CSR_DIR_Z = 2'd2
   } csr_index_type;

   typedef logic [2:0][15:0] vec_type;
   typedef logic [2:0][32:0] cvec_type;

   typedef struct packed {
      vec_type z;
      vec_type xa;
      logic    bad;
   } tag_type;

   typedef struct packed {
      tag_type          tag;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             zero;
      logic [63:0]      s;
      logic [33:0]      rem;
      logic [31:0]      root;
   } sq_type;

   typedef struct packed {
      tag_type                    tag;
      logic [2:0]                 neg;
      logic                       zero;
      logic [32:0]                d;
      logic [2:0][32:0]           rem;
      logic [2:0][QUOT_BITS-1:0]  nlo;
      logic [2:0][QUOT_BITS-1:0]  q;
   } dv_type;

endpackage

FILE: src/tool_frame_from_normal.sv
// ----------------------------------------------------------------------------
// Tool frame from normal
// A request taken with start is registered, passes through cross product,
// normaliser, cross product and normaliser in turn, and its frame is strobed on rsp_valid from the output register.
// Throughput: one request per clock cycle; busy is high only during reset and in the cycle
// after reset, and the receiver cannot stall the pipeline.
// Reset clears the pipeline valid bits and loads the direction registers.
// ----------------------------------------------------------------------------
module tool_frame_from_normal import tff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_normal_x,
   input  logic [15:0] req_normal_y,
   input  logic [15:0] req_normal_z,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [15:0] rsp_xaxis_x,
   output logic [15:0] rsp_xaxis_y,
   output logic [15:0] rsp_xaxis_z,
   output logic [15:0] rsp_yaxis_x,
   output logic [15:0] rsp_yaxis_y,
   output logic [15:0] rsp_yaxis_z,
   output logic [15:0] rsp_zaxis_x,
   output logic [15:0] rsp_zaxis_y,
   output logic [15:0] rsp_zaxis_z,
   output logic        rsp_degenerate
);

   logic     busy_ff;
   vec_type  dir_ff;
   logic     v0_ff;
   vec_type  z_ff;
   vec_type  z_in;
   vec_type  req_n;
   tag_type  tag0;
   logic     x1_v;
   cvec_type x1_c;
   tag_type  x1_tag;
   logic     n1_v;
   vec_type  n1_u;
   logic     n1_zero;
   tag_type  n1_tag;
   tag_type  tag2;
   logic     x2_v;
   cvec_type x2_c;
   tag_type  x2_tag;
   logic     n2_v;
   vec_type  n2_u;
   logic     n2_zero;
   tag_type  n2_tag;
   logic     out_v_ff;
   vec_type  out_x_ff;
   vec_type  out_y_ff;
   vec_type  out_z_ff;
   logic     out_bad_ff;

   assign req_n = {req_normal_z, req_normal_y, req_normal_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         z_in[i] = (req_n[i] == 16'h8000) ? 16'h7FFF : (16'd0 - req_n[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         v0_ff     <= 1'b0;
         out_v_ff  <= 1'b0;
         dir_ff[0] <= DIR_X_RESET;
         dir_ff[1] <= DIR_Y_RESET;
         dir_ff[2] <= DIR_Z_RESET;
      end else begin
         busy_ff  <= 1'b0;
         v0_ff    <= start && !busy_ff;
         out_v_ff <= n2_v;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DIR_X: dir_ff[0] <= csr_wdata;
               CSR_DIR_Y: dir_ff[1] <= csr_wdata;
               CSR_DIR_Z: dir_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      z_ff       <= z_in;
      out_x_ff   <= n2_tag.xa;
      out_y_ff   <= n2_u;
      out_z_ff   <= n2_tag.z;
      out_bad_ff <= n2_tag.bad || n2_zero;
   end

   assign tag0 = '{z: z_ff, xa: '0, bad: 1'b0};

   tff_cross u_cross1 (
      .clock, .reset, .in_valid(v0_ff), .in_a(dir_ff), .in_b(z_ff), .in_tag(tag0),
      .out_valid(x1_v), .out_c(x1_c), .out_tag(x1_tag)
   );

   tff_norm u_norm1 (
      .clock, .reset, .in_valid(x1_v), .in_c(x1_c), .in_tag(x1_tag),
      .out_valid(n1_v), .out_u(n1_u), .out_zero(n1_zero), .out_tag(n1_tag)
   );

   assign tag2 = '{z: n1_tag.z, xa: n1_u, bad: n1_zero};

   tff_cross u_cross2 (
      .clock, .reset, .in_valid(n1_v), .in_a(n1_tag.z), .in_b(n1_u), .in_tag(tag2),
      .out_valid(x2_v), .out_c(x2_c), .out_tag(x2_tag)
   );

   tff_norm u_norm2 (
      .clock, .reset, .in_valid(x2_v), .in_c(x2_c), .in_tag(x2_tag),
      .out_valid(n2_v), .out_u(n2_u), .out_zero(n2_zero), .out_tag(n2_tag)
   );

   assign busy           = busy_ff;
   assign rsp_valid      = out_v_ff;
   assign rsp_xaxis_x    = out_x_ff[0];
   assign rsp_xaxis_y    = out_x_ff[1];
   assign rsp_xaxis_z    = out_x_ff[2];
   assign rsp_yaxis_x    = out_y_ff[0];
   assign rsp_yaxis_y    = out_y_ff[1];
   assign rsp_yaxis_z    = out_y_ff[2];
   assign rsp_zaxis_x    = out_z_ff[0];
   assign rsp_zaxis_y    = out_z_ff[1];
   assign rsp_zaxis_z    = out_z_ff[2];
   assign rsp_degenerate = out_bad_ff;

   a_unit_axes_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         (out_x_ff != '0) && (out_y_ff != '0))
      else $error("frame reported valid with a zero axis");

   a_zero_x_gives_zero_y: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_x_ff == '0) |-> (out_y_ff == '0) && rsp_degenerate)
      else $error("zero x axis without zero y axis and degenerate flag");

   a_z_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zaxis_x != 16'h8000) && (rsp_zaxis_y != 16'h8000)
         && (rsp_zaxis_z != 16'h8000))
      else $error("z axis holds the most negative value");

endmodule

FILE: src/tff_cross.sv
// ----------------------------------------------------------------------------
// Cross product stage
// Two register stages: six products, then the three differences.
// ----------------------------------------------------------------------------
module tff_cross import tff_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  vec_type  in_a,
   input  vec_type  in_b,
   input  tag_type  in_tag,
   output logic     out_valid,
   output cvec_type out_c,
   output tag_type  out_tag
);

   logic signed [31:0] prod_in [6];
   logic signed [31:0] prod_ff [6];
   tag_type            tag1_ff;
   logic               v1_ff;
   cvec_type           c_in;
   cvec_type           c_ff;
   tag_type            tag2_ff;
   logic               v2_ff;

   always_comb begin
      prod_in[0] = $signed(in_a[1]) * $signed(in_b[2]);
      prod_in[1] = $signed(in_a[2]) * $signed(in_b[1]);
      prod_in[2] = $signed(in_a[2]) * $signed(in_b[0]);
      prod_in[3] = $signed(in_a[0]) * $signed(in_b[2]);
      prod_in[4] = $signed(in_a[0]) * $signed(in_b[1]);
      prod_in[5] = $signed(in_a[1]) * $signed(in_b[0]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = {prod_ff[2*i][31], prod_ff[2*i]} - {prod_ff[2*i+1][31], prod_ff[2*i+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      tag1_ff <= in_tag;
      c_ff    <= c_in;
      tag2_ff <= tag1_ff;
   end

   assign out_valid = v2_ff;
   assign out_c     = c_ff;
   assign out_tag   = tag2_ff;

endmodule

FILE: src/tff_norm.sv
// ----------------------------------------------------------------------------
// Vector normaliser
// Squares and sum, a one-bit-per-stage square root, then a one-bit-per-stage
// divider in three lanes, giving a rounded Q2.14 unit vector.
// ----------------------------------------------------------------------------
module tff_norm import tff_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  cvec_type in_c,
   input  tag_type  in_tag,
   output logic     out_valid,
   output vec_type  out_u,
   output logic     out_zero,
   output tag_type  out_tag
);

   logic             a_v_ff;
   tag_type          a_tag_ff;
   logic [2:0][31:0] a_mag_ff;
   logic [2:0][31:0] a_mag_in;
   logic [2:0]       a_neg_ff;
   logic             b_v_ff;
   tag_type          b_tag_ff;
   logic [2:0][31:0] b_mag_ff;
   logic [2:0]       b_neg_ff;
   logic [2:0][63:0] b_sq_ff;
   logic [2:0][63:0] b_sq_in;
   logic             sq_v_ff [SQRT_STEPS+1];
   sq_type           sq_ff   [SQRT_STEPS+1];
   sq_type           sq_in   [SQRT_STEPS+1];
   logic             dv_v_ff [QUOT_BITS+1];
   dv_type           dv_ff   [QUOT_BITS+1];
   dv_type           dv_in   [QUOT_BITS+1];
   logic             f_v_ff;
   vec_type          f_u_ff;
   vec_type          f_u_in;
   logic             f_zero_ff;
   tag_type          f_tag_ff;

   always_comb begin
      logic [32:0] m;
      for (int i = 0; i < 3; i++) begin
         m = in_c[i][32] ? (33'd0 - in_c[i]) : in_c[i];
         a_mag_in[i] = m[31:0];
         b_sq_in[i]  = a_mag_ff[i] * a_mag_ff[i];
      end
   end

   always_comb begin
      logic [35:0] remn;
      logic [35:0] trial;
      logic        ge;
      sq_in[0]      = '0;
      sq_in[0].tag  = b_tag_ff;
      sq_in[0].mag  = b_mag_ff;
      sq_in[0].neg  = b_neg_ff;
      sq_in[0].s    = b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      sq_in[0].zero = (sq_in[0].s == 64'd0);
      for (int k = 0; k < SQRT_STEPS; k++) begin
         remn  = {sq_ff[k].rem, sq_ff[k].s[63:62]};
         trial = {2'b00, sq_ff[k].root, 2'b01};
         ge    = (remn >= trial);
         sq_in[k+1]      = sq_ff[k];
         sq_in[k+1].s    = {sq_ff[k].s[61:0], 2'b00};
         sq_in[k+1].rem  = ge ? (remn[33:0] - trial[33:0]) : remn[33:0];
         sq_in[k+1].root = {sq_ff[k].root[30:0], ge};
      end
   end

   always_comb begin
      logic [47:0] n;
      logic [33:0] remn;
      logic        ge;
      dv_in[0]      = '0;
      dv_in[0].tag  = sq_ff[SQRT_STEPS].tag;
      dv_in[0].neg  = sq_ff[SQRT_STEPS].neg;
      dv_in[0].zero = sq_ff[SQRT_STEPS].zero;
      dv_in[0].d    = {sq_ff[SQRT_STEPS].root, 1'b0};
      for (int i = 0; i < 3; i++) begin
         n = {1'b0, sq_ff[SQRT_STEPS].mag[i], 15'd0} + {16'd0, sq_ff[SQRT_STEPS].root};
         dv_in[0].rem[i] = n[47:15];
         dv_in[0].nlo[i] = n[14:0];
      end
      for (int k = 0; k < QUOT_BITS; k++) begin
         dv_in[k+1] = dv_ff[k];
         for (int i = 0; i < 3; i++) begin
            remn = {dv_ff[k].rem[i], dv_ff[k].nlo[i][QUOT_BITS-1]};
            ge   = (remn >= {1'b0, dv_ff[k].d});
            dv_in[k+1].rem[i] = ge ? (remn[32:0] - dv_ff[k].d) : remn[32:0];
            dv_in[k+1].nlo[i] = {dv_ff[k].nlo[i][QUOT_BITS-2:0], 1'b0};
            dv_in[k+1].q[i]   = {dv_ff[k].q[i][QUOT_BITS-2:0], ge};
         end
      end
   end

   always_comb begin
      logic [15:0] qv;
      for (int i = 0; i < 3; i++) begin
         qv = {1'b0, dv_ff[QUOT_BITS].q[i]};
         if (dv_ff[QUOT_BITS].zero) begin
            f_u_in[i] = 16'd0;
         end else if (dv_ff[QUOT_BITS].neg[i]) begin
            f_u_in[i] = 16'd0 - qv;
         end else begin
            f_u_in[i] = qv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STEPS; k++) sq_v_ff[k] <= 1'b0;
         for (int k = 0; k <= QUOT_BITS; k++) dv_v_ff[k] <= 1'b0;
      end else begin
         a_v_ff     <= in_valid;
         b_v_ff     <= a_v_ff;
         sq_v_ff[0] <= b_v_ff;
         for (int k = 0; k < SQRT_STEPS; k++) sq_v_ff[k+1] <= sq_v_ff[k];
         dv_v_ff[0] <= sq_v_ff[SQRT_STEPS];
         for (int k = 0; k < QUOT_BITS; k++) dv_v_ff[k+1] <= dv_v_ff[k];
         f_v_ff     <= dv_v_ff[QUOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      a_tag_ff <= in_tag;
      a_mag_ff <= a_mag_in;
      for (int i = 0; i < 3; i++) a_neg_ff[i] <= in_c[i][32];
      b_tag_ff <= a_tag_ff;
      b_mag_ff <= a_mag_ff;
      b_neg_ff <= a_neg_ff;
      b_sq_ff  <= b_sq_in;
      for (int k = 0; k <= SQRT_STEPS; k++) sq_ff[k] <= sq_in[k];
      for (int k = 0; k <= QUOT_BITS; k++) dv_ff[k] <= dv_in[k];
      f_u_ff    <= f_u_in;
      f_zero_ff <= dv_ff[QUOT_BITS].zero;
      f_tag_ff  <= dv_ff[QUOT_BITS].tag;
   end

   assign out_valid = f_v_ff;
   assign out_u     = f_u_ff;
   assign out_zero  = f_zero_ff;
   assign out_tag   = f_tag_ff;

endmodule

FILE: sim/tff_frame_monitor.sv
// ----------------------------------------------------------------------------
// Tool frame monitor
// Watches the request, response and register channels of the tool frame
// block. It predicts the frame for every accepted request and compares each
// strobed response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tff_frame_monitor import tff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_normal_x,
   input  logic [15:0] req_normal_y,
   input  logic [15:0] req_normal_z,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_xaxis_x,
   input  logic [15:0] rsp_xaxis_y,
   input  logic [15:0] rsp_xaxis_z,
   input  logic [15:0] rsp_yaxis_x,
   input  logic [15:0] rsp_yaxis_y,
   input  logic [15:0] rsp_yaxis_z,
   input  logic [15:0] rsp_zaxis_x,
   input  logic [15:0] rsp_zaxis_y,
   input  logic [15:0] rsp_zaxis_z,
   input  logic        rsp_degenerate,
   output int          fail_count,
   output int          frames_pending
);

   typedef struct packed {
      logic [2:0][15:0] xa;
      logic [2:0][15:0] ya;
      logic [2:0][15:0] za;
      logic             degenerate;
   } frame_type;

   typedef longint vec3_type [3];

   frame_type   expected_frames [$];
   logic [15:0] dir_x = DIR_X_RESET;
   logic [15:0] dir_y = DIR_Y_RESET;
   logic [15:0] dir_z = DIR_Z_RESET;

   initial fail_count = 0;
   assign frames_pending = expected_frames.size();

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned root;
      longint unsigned bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > s) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (s >= root + bit_w) begin
            s    = s - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   function automatic vec3_type cross_product(vec3_type a, vec3_type b);
      vec3_type c;
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      return c;
   endfunction

   // Scales c to unit length in Q2.14; returns zero and clears ok when c is zero.
   function automatic vec3_type unit_vector(vec3_type c, output bit ok);
      vec3_type        u;
      longint unsigned mag [3];
      longint unsigned s;
      longint unsigned r;
      longint unsigned q;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
         s += mag[i] * mag[i];
      end
      ok = (s != 0);
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (ok) begin
         r = int_sqrt(s);
         for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 32768 + r) / (2 * r);
            if (c[i] < 0) u[i] = (q > 32768) ? -32768 : -longint'(q);
            else          u[i] = (q > 32767) ? 32767 : longint'(q);
         end
      end
      return u;
   endfunction

   function automatic frame_type predict_frame(logic [2:0][15:0] normal,
                                               logic [2:0][15:0] dir);
      frame_type f;
      vec3_type  d, z, xa, ya;
      bit        ok_x, ok_y;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($signed(dir[i]));
         z[i] = ($signed(normal[i]) == -32768) ? 32767 : -longint'($signed(normal[i]));
      end
      xa = unit_vector(cross_product(d, z), ok_x);
      ya = unit_vector(cross_product(z, xa), ok_y);
      for (int i = 0; i < 3; i++) begin
         f.xa[i] = xa[i][15:0];
         f.ya[i] = ya[i][15:0];
         f.za[i] = z[i][15:0];
      end
      f.degenerate = !(ok_x && ok_y);
      return f;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      frame_type want;
      if (reset) begin
         dir_x <= DIR_X_RESET;
         dir_y <= DIR_Y_RESET;
         dir_z <= DIR_Z_RESET;
      end else begin
         if (start && !busy)
            expected_frames.insert(expected_frames.size(), predict_frame(
               {req_normal_z, req_normal_y, req_normal_x}, {dir_z, dir_y, dir_x}));
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DIR_X: dir_x <= csr_wdata;
               CSR_DIR_Y: dir_y <= csr_wdata;
               CSR_DIR_Z: dir_z <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_xaxis_x !== want.xa[0]) report_mismatch("xaxis_x", rsp_xaxis_x, want.xa[0]);
               if (rsp_xaxis_y !== want.xa[1]) report_mismatch("xaxis_y", rsp_xaxis_y, want.xa[1]);
               if (rsp_xaxis_z !== want.xa[2]) report_mismatch("xaxis_z", rsp_xaxis_z, want.xa[2]);
               if (rsp_yaxis_x !== want.ya[0]) report_mismatch("yaxis_x", rsp_yaxis_x, want.ya[0]);
               if (rsp_yaxis_y !== want.ya[1]) report_mismatch("yaxis_y", rsp_yaxis_y, want.ya[1]);
               if (rsp_yaxis_z !== want.ya[2]) report_mismatch("yaxis_z", rsp_yaxis_z, want.ya[2]);
               if (rsp_zaxis_x !== want.za[0]) report_mismatch("zaxis_x", rsp_zaxis_x, want.za[0]);
               if (rsp_zaxis_y !== want.za[1]) report_mismatch("zaxis_y", rsp_zaxis_y, want.za[1]);
               if (rsp_zaxis_z !== want.za[2]) report_mismatch("zaxis_z", rsp_zaxis_z, want.za[2]);
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch("degenerate", 16'(rsp_degenerate), 16'(want.degenerate));
            end
         end
      end
   end

endmodule

FILE: sim/tool_frame_from_normal_tb.sv
// ----------------------------------------------------------------------------
// Tool frame from normal testbench
// Streams surface normals into the block in random bursts under a series of
// travel directions, extremes included, and leaves the checking to the
// frame monitor beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tool_frame_from_normal_tb;
   import tff_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_normal_x = '0;
   logic [15:0] req_normal_y = '0;
   logic [15:0] req_normal_z = '0;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_DIR_X;
   logic [15:0] csr_wdata = '0;
   logic        rsp_valid;
   logic [15:0] rsp_xaxis_x, rsp_xaxis_y, rsp_xaxis_z;
   logic [15:0] rsp_yaxis_x, rsp_yaxis_y, rsp_yaxis_z;
   logic [15:0] rsp_zaxis_x, rsp_zaxis_y, rsp_zaxis_z;
   logic        rsp_degenerate;
   int          fail_count;
   int          frames_pending;

   logic [2:0][15:0] cur_dir = {DIR_Z_RESET, DIR_Y_RESET, DIR_X_RESET};
   int               burst_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tool_frame_from_normal i_dut (.*);

   tff_frame_monitor i_monitor (.*);

   initial begin
      #20_000_000;
      $display("FAIL tool_frame_from_normal");
      $finish;
   end

   task automatic write_direction(logic [2:0][15:0] dir);
      for (int i = 0; i < 3; i++) begin
         @(negedge clock);
         csr_we    = 1'b1;
         csr_index = csr_index_type'(i);
         csr_wdata = dir[i];
      end
      @(negedge clock);
      csr_we  = 1'b0;
      cur_dir = dir;
   endtask

   // Sends one normal; bursts of back-to-back requests are split by random gaps, which a burst skips one time in three.
   task automatic send_normal(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start        = 1'b1;
      req_normal_x = nx;
      req_normal_y = ny;
      req_normal_z = nz;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [15:0] pick_extreme();
      logic [15:0] vals [8] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
                                16'h0001, 16'h7FFF, 16'h4000, 16'hC000};
      return vals[$urandom_range(0, 7)];
   endfunction

   function automatic logic [15:0] scaled(logic [15:0] v, int k);
      int p;
      p = int'($signed(v)) * k / 4;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p[15:0];
   endfunction

   task automatic send_random_normal();
      logic [2:0][15:0] n;
      int               k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: for (int i = 0; i < 3; i++) n[i] = 16'($urandom_range(0, 65535));
         5, 6: for (int i = 0; i < 3; i++) n[i] = 16'($urandom_range(0, 400) - 200);
         7: begin
            k = $urandom_range(0, 8) - 4;
            for (int i = 0; i < 3; i++) n[i] = scaled(cur_dir[i], k);
         end
         8: for (int i = 0; i < 3; i++) n[i] = pick_extreme();
         default: begin
            n = '0;
            n[2'($urandom_range(0, 2))] = 16'($urandom_range(0, 65535));
         end
      endcase
      send_normal(n[0], n[1], n[2]);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      burst_left = 0;
      wait (frames_pending == 0);
      repeat (120) @(negedge clock);
   endtask

   initial begin
      logic [2:0][15:0] dirs [6];
      dirs[0] = {DIR_Z_RESET, DIR_Y_RESET, DIR_X_RESET};
      dirs[1] = {16'h8000, 16'h8000, 16'h8000};
      dirs[2] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      dirs[3] = {16'h0000, 16'h0000, 16'h0000};
      dirs[4] = {16'h0000, 16'h0000, 16'h4000};
      dirs[5] = {16'($urandom), 16'($urandom), 16'($urandom)};

      repeat (3) @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < 7; p++) begin
         if (p > 0) begin
            drain();
            if (p < 6) write_direction(dirs[p]);
            else write_direction({16'($urandom), 16'($urandom), 16'($urandom)});
         end
         if (p == 0) begin
            send_normal(16'h0000, 16'h0000, 16'h0000);
            send_normal(16'h8000, 16'h8000, 16'h8000);
            send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
            send_normal(16'h0000, 16'h4000, 16'h0000);
            send_normal(16'h0000, 16'hC000, 16'h0000);
            send_normal(16'h0000, 16'h8000, 16'h0000);
            send_normal(16'h0000, 16'h0000, 16'hC000);
            send_normal(16'h4000, 16'h0000, 16'h0000);
            send_normal(16'h8000, 16'h7FFF, 16'h0001);
            send_normal(16'hFFFF, 16'h0001, 16'h8000);
            send_normal(16'h2D41, 16'h0000, 16'hD2BF);
            send_normal(16'h0001, 16'h0000, 16'h0000);
         end
         repeat (280) send_random_normal();
      end

      drain();
      if (fail_count == 0) begin
         $display("PASS tool_frame_from_normal");
      end else begin
         $display("FAIL tool_frame_from_normal");
      end
      $finish;
   end

endmodule

FILE: tool_frame_from_normal.f
src/tff_pkg.sv
src/tff_cross.sv
src/tff_norm.sv
src/tool_frame_from_normal.sv
sim/tff_frame_monitor.sv
sim/tool_frame_from_normal_tb.sv
